// File: src/hyperspectral_reformat_address_gen_macros.svh
// Assertion macros shared by the reformat address generator modules.
`ifndef HYPERSPECTRAL_REFORMAT_ADDRESS_GEN_MACROS_SVH
`define HYPERSPECTRAL_REFORMAT_ADDRESS_GEN_MACROS_SVH

// Same-cycle implication, sampled on aclk and switched off while aresetn is low.
`define HRAG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hrag: assertion failed");

// Next-cycle implication, sampled on aclk and switched off while aresetn is low.
`define HRAG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hrag: assertion failed");

`endif

// File: src/hrag_pkg.sv
// Types and constants shared by the reformat address generator modules.
package hrag_pkg;

    localparam int unsigned AddrW  = 36;
    localparam int unsigned SampW  = 13;
    localparam int unsigned LineW  = 13;
    localparam int unsigned BandW  = 10;
    localparam int unsigned CfgIdxW = 3;

    // Interleave codes.
    localparam logic [1:0] FMT_BIL = 2'd0;
    localparam logic [1:0] FMT_BIP = 2'd1;
    localparam logic [1:0] FMT_BSQ = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_SRC_FORMAT = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_DST_FORMAT = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ELEM_LOG2  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_FRAME_DIMS = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_ROI_START  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_ROI_END    = 3'd5;

    typedef enum logic [1:0] {
        RES_OK         = 2'd0,
        RES_BAD_REGION = 2'd1,
        RES_FINISHED   = 2'd2
    } res_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC1,
        ST_CALC2,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic        accept;
        logic        calc1;
        logic        calc2;
        logic        emit;
        res_status_t emit_status;
    } hrag_cmd_t;

    typedef struct packed {
        logic active;
        logic region_ok;
        logic out_free;
    } hrag_stat_t;

endpackage

// File: src/hrag_ctrl.sv
// Sequencing state machine of the reformat address generator.
`include "hyperspectral_reformat_address_gen_macros.svh"
module hrag_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  hrag_pkg::hrag_stat_t stat,
    output hrag_pkg::hrag_cmd_t  cmd
);
    import hrag_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd.accept      = 1'b0;
        cmd.calc1       = 1'b0;
        cmd.calc2       = 1'b0;
        cmd.emit        = 1'b0;
        cmd.emit_status = RES_OK;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CALC1;
                end
            end
            ST_CALC1: begin
                cmd.calc1 = 1'b1;
                if (!stat.active || !stat.region_ok) begin
                    // Error results need no arithmetic; wait only for the output slot.
                    cmd.emit_status = stat.active ? RES_BAD_REGION : RES_FINISHED;
                    if (stat.out_free) begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_CALC2;
                end
            end
            ST_CALC2: begin
                cmd.calc2  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `HRAG_ASSERT_NXT(a_accept_starts_calc, in_valid && in_ready, state_reg == ST_CALC1)
    `HRAG_ASSERT_IMP(a_emit_needs_slot, cmd.emit, stat.out_free)
    `HRAG_ASSERT_IMP(a_accept_alone, cmd.accept, !cmd.emit && !cmd.calc1 && !cmd.calc2)

endmodule

// File: src/hrag_datapath.sv
// Configuration registers, walk counters, address arithmetic and output register.
`include "hyperspectral_reformat_address_gen_macros.svh"
module hrag_datapath #(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned MAX_LINES   = 4096,
    parameter int unsigned MAX_BANDS   = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [hrag_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [hrag_pkg::AddrW-1:0]     cfg_data,
    input  logic                           restart,
    input  hrag_pkg::hrag_cmd_t            cmd,
    output hrag_pkg::hrag_stat_t           stat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [hrag_pkg::AddrW-1:0]     out_src_addr,
    output logic [hrag_pkg::AddrW-1:0]     out_dst_addr,
    output logic                           out_last,
    output hrag_pkg::res_status_t          out_status
);
    import hrag_pkg::*;

    logic [1:0]       src_fmt_reg, dst_fmt_reg, elem_log2_reg;
    logic [AddrW-1:0] frame_reg, rstart_reg, rend_reg;

    logic [SampW-1:0] sample_pos_reg;
    logic [LineW-1:0] line_pos_reg;
    logic [BandW-1:0] band_pos_reg;
    logic             active_reg;

    logic [26:0] src_p1_reg, src_p2_reg, dst_p1_reg, dst_p2_reg;
    logic [13:0] src_c_reg, dst_c_reg;
    logic [12:0] src_y_reg, dst_y_reg;
    logic [AddrW-1:0] src_p3_reg, dst_p3_reg;

    logic             out_valid_reg, out_last_reg;
    logic [AddrW-1:0] out_src_reg, out_dst_reg;
    res_status_t      out_status_reg;

    logic [SampW-1:0] fs, st_s, en_s, ext_s;
    logic [LineW-1:0] fl, st_l, en_l, ext_l;
    logic [BandW-1:0] fb, st_b, en_b, ext_b;
    logic [13:0]      s_abs, l_abs;
    logic [10:0]      b_abs;
    logic             region_ok;

    logic [13:0] src_a, src_b, src_c, dst_a, dst_b, dst_c;
    logic [12:0] src_x, src_y, src_z, dst_x, dst_y, dst_z;
    logic [39:0] src_p3_full, dst_p3_full;
    logic [AddrW-1:0] src_idx, dst_idx;

    logic s_wrap, l_wrap, b_wrap;
    logic step_s, step_l, step_b, walk_done;
    logic out_free;

    assign fs   = frame_reg[12:0];
    assign fl   = frame_reg[25:13];
    assign fb   = frame_reg[35:26];
    assign st_s = rstart_reg[12:0];
    assign st_l = rstart_reg[25:13];
    assign st_b = rstart_reg[35:26];
    assign en_s = rend_reg[12:0];
    assign en_l = rend_reg[25:13];
    assign en_b = rend_reg[35:26];

    assign ext_s = en_s - st_s;
    assign ext_l = en_l - st_l;
    assign ext_b = en_b - st_b;

    assign s_abs = {1'b0, st_s} + {1'b0, sample_pos_reg};
    assign l_abs = {1'b0, st_l} + {1'b0, line_pos_reg};
    assign b_abs = {1'b0, st_b} + {1'b0, band_pos_reg};

    assign region_ok = (src_fmt_reg != 2'd3) && (dst_fmt_reg != 2'd3)
                    && ({1'b0, fs} <= 14'(MAX_SAMPLES))
                    && ({1'b0, fl} <= 14'(MAX_LINES))
                    && ({1'b0, fb} <= 11'(MAX_BANDS))
                    && (st_s < en_s) && (en_s <= fs)
                    && (st_l < en_l) && (en_l <= fl)
                    && (st_b < en_b) && (en_b <= fb);

    // Index = a*x*y + b*z + c; x is fs for the source, ext_s for the destination.
    always_comb begin
        src_x = fs;
        case (src_fmt_reg)
            FMT_BIL: begin
                src_a = l_abs;        src_y = {3'b0, fb};
                src_b = {3'b0, b_abs}; src_z = fs;           src_c = s_abs;
            end
            FMT_BIP: begin
                src_a = l_abs;        src_y = {3'b0, fb};
                src_b = s_abs;        src_z = {3'b0, fb};   src_c = {3'b0, b_abs};
            end
            default: begin
                src_a = {3'b0, b_abs}; src_y = fl;
                src_b = l_abs;        src_z = fs;           src_c = s_abs;
            end
        endcase
    end

    always_comb begin
        dst_x = ext_s;
        case (dst_fmt_reg)
            FMT_BIL: begin
                dst_a = {1'b0, line_pos_reg}; dst_y = {3'b0, ext_b};
                dst_b = {4'b0, band_pos_reg}; dst_z = ext_s;
                dst_c = {1'b0, sample_pos_reg};
            end
            FMT_BIP: begin
                dst_a = {1'b0, line_pos_reg};   dst_y = {3'b0, ext_b};
                dst_b = {1'b0, sample_pos_reg}; dst_z = {3'b0, ext_b};
                dst_c = {4'b0, band_pos_reg};
            end
            default: begin
                dst_a = {4'b0, band_pos_reg}; dst_y = ext_l;
                dst_b = {1'b0, line_pos_reg}; dst_z = ext_s;
                dst_c = {1'b0, sample_pos_reg};
            end
        endcase
    end

    assign src_p3_full = src_p1_reg * src_y_reg;
    assign dst_p3_full = dst_p1_reg * dst_y_reg;
    assign src_idx = src_p3_reg + {9'b0, src_p2_reg} + {22'b0, src_c_reg};
    assign dst_idx = dst_p3_reg + {9'b0, dst_p2_reg} + {22'b0, dst_c_reg};

    // Counter carries; the step logic below orders them by destination format.
    assign s_wrap = ({1'b0, sample_pos_reg} + 14'd1) >= {1'b0, ext_s};
    assign l_wrap = ({1'b0, line_pos_reg} + 14'd1) >= {1'b0, ext_l};
    assign b_wrap = ({1'b0, band_pos_reg} + 11'd1) >= {1'b0, ext_b};

    always_comb begin
        case (dst_fmt_reg)
            FMT_BIL: begin
                step_s    = 1'b1;
                step_b    = s_wrap;
                step_l    = s_wrap && b_wrap;
                walk_done = step_l && l_wrap;
            end
            FMT_BIP: begin
                step_b    = 1'b1;
                step_s    = b_wrap;
                step_l    = b_wrap && s_wrap;
                walk_done = step_l && l_wrap;
            end
            default: begin
                step_s    = 1'b1;
                step_l    = s_wrap;
                step_b    = s_wrap && l_wrap;
                walk_done = step_b && b_wrap;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg   <= FMT_BIL;
            dst_fmt_reg   <= FMT_BIL;
            elem_log2_reg <= 2'd0;
            frame_reg     <= '0;
            rstart_reg    <= '0;
            rend_reg      <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SRC_FORMAT: src_fmt_reg   <= cfg_data[1:0];
                CFG_DST_FORMAT: dst_fmt_reg   <= cfg_data[1:0];
                CFG_ELEM_LOG2:  elem_log2_reg <= cfg_data[1:0];
                CFG_FRAME_DIMS: frame_reg     <= cfg_data;
                CFG_ROI_START:  rstart_reg    <= cfg_data;
                CFG_ROI_END:    rend_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_pos_reg <= '0;
            line_pos_reg   <= '0;
            band_pos_reg   <= '0;
            active_reg     <= 1'b0;
        end else if (cmd.accept && restart) begin
            sample_pos_reg <= '0;
            line_pos_reg   <= '0;
            band_pos_reg   <= '0;
            active_reg     <= 1'b1;
        end else if (cmd.emit) begin
            if (cmd.emit_status == RES_OK) begin
                if (step_s) sample_pos_reg <= s_wrap ? '0 : sample_pos_reg + 13'd1;
                if (step_l) line_pos_reg   <= l_wrap ? '0 : line_pos_reg + 13'd1;
                if (step_b) band_pos_reg   <= b_wrap ? '0 : band_pos_reg + 10'd1;
                if (walk_done) active_reg  <= 1'b0;
            end else begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc1) begin
            src_p1_reg <= src_a * src_x;
            src_p2_reg <= src_b * src_z;
            src_c_reg  <= src_c;
            src_y_reg  <= src_y;
            dst_p1_reg <= dst_a * dst_x;
            dst_p2_reg <= dst_b * dst_z;
            dst_c_reg  <= dst_c;
            dst_y_reg  <= dst_y;
        end
        if (cmd.calc2) begin
            src_p3_reg <= src_p3_full[AddrW-1:0];
            dst_p3_reg <= dst_p3_full[AddrW-1:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg <= cmd.emit_status;
            if (cmd.emit_status == RES_OK) begin
                out_src_reg  <= src_idx << elem_log2_reg;
                out_dst_reg  <= dst_idx << elem_log2_reg;
                out_last_reg <= walk_done;
            end else begin
                out_src_reg  <= '0;
                out_dst_reg  <= '0;
                out_last_reg <= 1'b0;
            end
        end
    end

    assign stat.active    = active_reg;
    assign stat.region_ok = region_ok;
    assign stat.out_free  = out_free;

    assign out_valid    = out_valid_reg;
    assign out_src_addr = out_src_reg;
    assign out_dst_addr = out_dst_reg;
    assign out_last     = out_last_reg;
    assign out_status   = out_status_reg;

    `HRAG_ASSERT_IMP(a_error_result_zero, out_valid_reg && (out_status_reg != RES_OK),
        (out_src_reg == '0) && (out_dst_reg == '0) && !out_last_reg)
    `HRAG_ASSERT_NXT(a_last_ends_walk,
        cmd.emit && (cmd.emit_status == RES_OK) && walk_done, !active_reg)
    `HRAG_ASSERT_NXT(a_bad_region_ends_walk,
        cmd.emit && (cmd.emit_status == RES_BAD_REGION), !active_reg && out_valid_reg)

endmodule

// File: src/hyperspectral_reformat_address_gen.sv
// Top level of the hyperspectral reformat address generator.
// After acceptance an address pair passes the states CALC1, CALC2 (the two registered
// multiply stages of the index arithmetic) and EMIT before it is registered on the master
// side; a bad-region or walk-finished result is registered from CALC1. Both wait while the
// output slot is not free. A new request is taken only in IDLE, after the last result.
// Reset (aresetn low, synchronous) clears the configuration, the walk counters and the output valid.
module hyperspectral_reformat_address_gen #(
    parameter int unsigned MAX_SAMPLES = 4096,
    parameter int unsigned MAX_LINES   = 4096,
    parameter int unsigned MAX_BANDS   = 512
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration write port; index follows the register list, no read-back.
    input  logic                         cfg_we,
    input  logic [hrag_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [hrag_pkg::AddrW-1:0]   cfg_data,
    // Request stream.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [0] restart, [7:1] zero
    // Result stream.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [71:0]                  m_axis_tdata,   // [35:0] src_addr, [71:36] dst_addr
    output logic                         m_axis_tlast,   // last element of the walk
    output logic [1:0]                   m_axis_tuser    // [1:0] status
);
    import hrag_pkg::*;

    // The controller sequences each request through the arithmetic of the datapath:
    // acceptance, a first product stage that also checks the region, a second product
    // stage and the final sum, written to the output register with the step of the walk
    // counters (an error result goes from the first stage). The output register lets a
    // finished result wait for the consumer while the next request is taken.
    hrag_cmd_t   cmd;
    hrag_stat_t  stat;
    res_status_t status;
    logic [AddrW-1:0] src_addr, dst_addr;

    hrag_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hrag_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_LINES   (MAX_LINES),
        .MAX_BANDS   (MAX_BANDS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .restart      (s_axis_tdata[0]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_src_addr (src_addr),
        .out_dst_addr (dst_addr),
        .out_last     (m_axis_tlast),
        .out_status   (status)
    );

    // Source address in the low half of the data word, destination in the high half.
    assign m_axis_tdata = {dst_addr, src_addr};
    assign m_axis_tuser = status;

endmodule
